// ===== src/pgbh_pkg.sv =====
// Shared types and constants for the point grid binning histogram.
// No dependencies; the design files that use it refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps
package pgbh_pkg;

    // Field widths of the item channels
    localparam int CMD_W   = 2;
    localparam int COORD_W = 32;
    localparam int IDX8_W  = 8;
    localparam int CNT16_W = 16;
    localparam int PIX_W   = 8;
    localparam int OCC_W   = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int GRID_W     = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BINARY     = 3'd6;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Gray value evaluation
    localparam logic [31:0]      Q28_ONE      = 32'h1000_0000;
    localparam logic [4:0]       TAYLOR_TERMS = 5'd24;
    localparam logic [PIX_W-1:0] PIX_FULL     = 8'hFF;

    // Status from the binning unit
    typedef struct packed {
        logic done;
        logic ok;
    } t_bin_res;

endpackage

// ===== src/pgbh_if.sv =====
// Item channel interfaces: command items in, result items out.
// Depends on pgbh_pkg for field widths.
`timescale 1ns / 1ps
interface pgbh_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [pgbh_pkg::CMD_W-1:0]           cmd;
    logic signed [pgbh_pkg::COORD_W-1:0]  point_x;
    logic signed [pgbh_pkg::COORD_W-1:0]  point_y;
    logic [pgbh_pkg::IDX8_W-1:0]          read_col;
    logic [pgbh_pkg::IDX8_W-1:0]          read_row;

    modport source (output valid, cmd, point_x, point_y, read_col, read_row, input ready);
    modport sink   (input valid, cmd, point_x, point_y, read_col, read_row, output ready);
endinterface

interface pgbh_out_if;
    logic                           valid;
    logic                           ready;
    logic [pgbh_pkg::IDX8_W-1:0]    cell_col;
    logic [pgbh_pkg::IDX8_W-1:0]    cell_row;
    logic                           in_range;
    logic [pgbh_pkg::CNT16_W-1:0]   cell_count;
    logic [pgbh_pkg::PIX_W-1:0]     pixel;
    logic [pgbh_pkg::OCC_W-1:0]     occupied_total;
    logic [pgbh_pkg::CNT16_W-1:0]   max_count;

    modport source (output valid, cell_col, cell_row, in_range, cell_count, pixel,
                     occupied_total, max_count, input ready);
    modport sink   (input valid, cell_col, cell_row, in_range, cell_count, pixel,
                     occupied_total, max_count, output ready);
endinterface

// ===== src/pgbh_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module pgbh_div #(
    parameter int NW = 40,
    parameter int DV = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DV-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CNW = $clog2(NW + 1);

    logic [CNW-1:0] r_cnt;
    logic           r_done;
    logic [NW-1:0]  r_quo;
    logic [DV-1:0]  r_rem;
    logic [DV-1:0]  r_den;

    logic [DV:0]    w_sh;
    logic [DV+1:0]  w_diff;
    logic           w_bit;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        w_sh   = {r_rem, r_quo[NW-1]};
        w_diff = {1'b0, w_sh} - {2'b00, r_den};
        w_bit  = !w_diff[DV+1];
    end

    // Count down the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_cnt == '0) begin
                if (i_start) begin
                    r_cnt <= CNW'(NW);
                end
            end else begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Hold the operands and partial results
    always_ff @(posedge i_clk) begin
        if (r_cnt == '0) begin
            if (i_start) begin
                r_quo <= i_num;
                r_rem <= '0;
                r_den <= i_den;
            end
        end else begin
            r_quo <= {r_quo[NW-2:0], w_bit};
            r_rem <= w_bit ? w_diff[DV-1:0] : w_sh[DV-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== src/pgbh_bin.sv =====
// Point binning: subtract origin, scale by reciprocal cell size, floor, bound.
// Depends on pgbh_pkg; shares one 32x32 multiplier between both axes.
`timescale 1ns / 1ps
module pgbh_bin #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256,
    parameter int CW       = 8,
    parameter int RW       = 8,
    parameter int LCW      = 9,
    parameter int LRW      = 9
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [pgbh_pkg::COORD_W-1:0]  i_point_x,
    input  logic signed [pgbh_pkg::COORD_W-1:0]  i_point_y,
    input  logic signed [pgbh_pkg::COORD_W-1:0]  i_origin_x,
    input  logic signed [pgbh_pkg::COORD_W-1:0]  i_origin_y,
    input  logic [pgbh_pkg::COORD_W-1:0]         i_inv_x,
    input  logic [pgbh_pkg::COORD_W-1:0]         i_inv_y,
    input  logic [LCW-1:0]                       i_cols,
    input  logic [LRW-1:0]                       i_rows,
    output pgbh_pkg::t_bin_res                   o_res,
    output logic [CW-1:0]                        o_col,
    output logic [RW-1:0]                        o_row
);
    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MX   = 2'd1;
    localparam logic [1:0] B_MY   = 2'd2;
    localparam logic [1:0] B_CHK  = 2'd3;

    logic [1:0]  r_state;
    logic [32:0] r_dx;
    logic [32:0] r_dy;
    logic [63:0] r_prod;
    logic [31:0] r_qx;
    logic [31:0] w_qy;
    logic        w_okx;
    logic        w_oky;

    // Sequence subtract, x product, y product, bound check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            case (r_state)
                B_IDLE:  r_state <= i_start ? B_MX : B_IDLE;
                B_MX:    r_state <= B_MY;
                B_MY:    r_state <= B_CHK;
                B_CHK:   r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Datapath: the multiplier takes one axis per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_dx <= {i_point_x[31], i_point_x} - {i_origin_x[31], i_origin_x};
                r_dy <= {i_point_y[31], i_point_y} - {i_origin_y[31], i_origin_y};
            end
            B_MX: begin
                r_prod <= r_dx[31:0] * i_inv_x;
            end
            B_MY: begin
                r_qx   <= r_prod[63:32];
                r_prod <= r_dy[31:0] * i_inv_y;
            end
            default: begin
            end
        endcase
    end

    // A negative offset lands in cell zero only when the scale is zero
    always_comb begin
        w_qy  = r_prod[63:32];
        w_okx = r_dx[32] ? (i_inv_x == '0) : (r_qx < 32'(i_cols));
        w_oky = r_dy[32] ? (i_inv_y == '0) : (w_qy < 32'(i_rows));
        o_res.done = (r_state == B_CHK);
        o_res.ok   = w_okx & w_oky;
        o_col = r_dx[32] ? '0 : r_qx[CW-1:0];
        o_row = r_dy[32] ? '0 : w_qy[RW-1:0];
    end
endmodule

// ===== src/pgbh_gray.sv =====
// Gray value floor(255*tanh(count/peak)) by ratio divide, Taylor series and
// final divide. Depends on pgbh_pkg and pgbh_div (one shared divider).
`timescale 1ns / 1ps
module pgbh_gray #(
    parameter int COUNT_BITS = 16,
    parameter int RATIO_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [COUNT_BITS-1:0]         i_count,
    input  logic [COUNT_BITS-1:0]         i_peak,
    output logic                          o_done,
    output logic [pgbh_pkg::PIX_W-1:0]    o_pixel
);
    localparam int NW = (COUNT_BITS + RATIO_BITS > 40) ? COUNT_BITS + RATIO_BITS : 40;
    localparam int DV = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    localparam logic [2:0] G_IDLE  = 3'd0;
    localparam logic [2:0] G_RAT   = 3'd1;
    localparam logic [2:0] G_MUL   = 3'd2;
    localparam logic [2:0] G_KDIV  = 3'd3;
    localparam logic [2:0] G_KWAIT = 3'd4;
    localparam logic [2:0] G_FDIV  = 3'd5;
    localparam logic [2:0] G_FWAIT = 3'd6;
    localparam logic [2:0] G_FIN   = 3'd7;

    logic [2:0]  r_state;
    logic [29:0] r_y;
    logic [31:0] r_t;
    logic [31:0] r_e;
    logic [61:0] r_p;
    logic [4:0]  r_k;
    logic [pgbh_pkg::PIX_W-1:0] r_pix;

    logic          w_zero;
    logic          w_dstart;
    logic [NW-1:0] w_dnum;
    logic [DV-1:0] w_dden;
    logic          w_ddone;
    logic [NW-1:0] w_dquo;
    logic [31:0]   w_ediff;
    logic [39:0]   w_fnum;

    pgbh_div #(.NW(NW), .DV(DV)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_ddone),
        .o_quo   (w_dquo)
    );

    // Pick the divider operands for the current step
    always_comb begin
        w_zero   = (i_count == '0) || (i_peak == '0);
        w_ediff  = r_e - pgbh_pkg::Q28_ONE;
        w_fnum   = {8'd0, w_ediff} * 40'(pgbh_pkg::PIX_FULL);
        w_dstart = 1'b0;
        w_dnum   = NW'({i_count, {RATIO_BITS{1'b0}}});
        w_dden   = DV'(i_peak);
        case (r_state)
            G_IDLE: begin
                w_dstart = i_start && !w_zero;
            end
            G_KDIV: begin
                w_dstart = 1'b1;
                w_dnum   = NW'(r_p[59:28]);
                w_dden   = DV'(r_k);
            end
            G_FDIV: begin
                w_dstart = 1'b1;
                w_dnum   = NW'(w_fnum);
                w_dden   = DV'(r_e + pgbh_pkg::Q28_ONE);
            end
            default: begin
            end
        endcase
    end

    // Advance the sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else begin
            case (r_state)
                G_IDLE: begin
                    if (i_start) begin
                        r_state <= w_zero ? G_FIN : G_RAT;
                    end
                end
                G_RAT:   r_state <= w_ddone ? G_MUL : G_RAT;
                G_MUL:   r_state <= G_KDIV;
                G_KDIV:  r_state <= G_KWAIT;
                G_KWAIT: begin
                    if (w_ddone) begin
                        r_state <= (r_k == pgbh_pkg::TAYLOR_TERMS) ? G_FDIV : G_MUL;
                    end
                end
                G_FDIV:  r_state <= G_FWAIT;
                G_FWAIT: r_state <= w_ddone ? G_FIN : G_FWAIT;
                G_FIN:   r_state <= G_IDLE;
                default: r_state <= G_IDLE;
            endcase
        end
    end

    // Series terms and running sum
    always_ff @(posedge i_clk) begin
        case (r_state)
            G_IDLE: begin
                r_pix <= '0;
            end
            G_RAT: begin
                r_y <= {w_dquo[RATIO_BITS:0], {(29 - RATIO_BITS){1'b0}}};
                r_t <= pgbh_pkg::Q28_ONE;
                r_e <= pgbh_pkg::Q28_ONE;
                r_k <= 5'd1;
            end
            G_MUL: begin
                r_p <= r_t * r_y;
            end
            G_KWAIT: begin
                if (w_ddone) begin
                    r_t <= w_dquo[31:0];
                    r_e <= r_e + w_dquo[31:0];
                    r_k <= r_k + 5'd1;
                end
            end
            G_FWAIT: begin
                if (w_ddone) begin
                    r_pix <= w_dquo[pgbh_pkg::PIX_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done  = (r_state == G_FIN);
    assign o_pixel = r_pix;
endmodule

// ===== src/point_grid_binning_histogram.sv =====
// Point grid binning histogram: bins Q16.16 points into a grid of cell counts
// held in one synchronous memory of MAX_COLS*MAX_ROWS entries. One command item
// is in work at a time. After reset and after every clear command the block
// walks the whole store writing zeros, one entry per cycle, and takes no item
// until every entry is cleared; configuration writes are taken throughout. An
// add runs offset, two products on one shared multiplier, bound check, memory
// read and write back. A read in binary mode is a bound check and memory read;
// in gray mode it adds 26 serial divides (the count/peak ratio, 24 Taylor terms
// and the final quotient) on one shared divider with an NW-bit dividend, where
// NW is the larger of 40 and COUNT_BITS+RATIO_BITS.
// Depends on pgbh_pkg, pgbh_if, pgbh_bin, pgbh_gray and pgbh_div.
`timescale 1ns / 1ps
module point_grid_binning_histogram #(
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 256,
    parameter int COUNT_BITS = 16,
    parameter int RATIO_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pgbh_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pgbh_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    pgbh_in_if.sink                             i_in,
    pgbh_out_if.source                          o_out
);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LCW   = $clog2(MAX_COLS + 1);
    localparam int LRW   = $clog2(MAX_ROWS + 1);
    localparam int OW    = $clog2(DEPTH + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_BIN  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_GRAY = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [COUNT_BITS-1:0] SAT = {COUNT_BITS{1'b1}};

    // Configuration registers
    logic signed [31:0] r_origin_x;
    logic signed [31:0] r_origin_y;
    logic [31:0]        r_inv_x;
    logic [31:0]        r_inv_y;
    logic [pgbh_pkg::GRID_W-1:0] r_gcols;
    logic [pgbh_pkg::GRID_W-1:0] r_grows;
    logic               r_binary;

    // Control and totals
    logic [2:0]            r_state;
    logic [AW-1:0]         r_clr_idx;
    logic                  r_clr_res;
    logic                  r_is_add;
    logic [AW-1:0]         r_addr;
    logic [COUNT_BITS-1:0] r_peak;
    logic [OW-1:0]         r_occ;
    logic                  r_ovalid;

    // Pending result and output register
    logic [7:0]              r_res_col;
    logic [7:0]              r_res_row;
    logic                    r_res_ok;
    logic [COUNT_BITS-1:0]   r_res_cnt;
    logic [7:0]              r_res_pix;
    logic [7:0]              r_o_col;
    logic [7:0]              r_o_row;
    logic                    r_o_ok;
    logic [15:0]             r_o_cnt;
    logic [7:0]              r_o_pix;
    logic [16:0]             r_o_occ;
    logic [15:0]             r_o_max;

    // Count store
    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rdata;

    logic [LCW-1:0]        w_cols;
    logic [LRW-1:0]        w_rows;
    logic                  w_accept;
    logic                  w_rd_ok;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_bin_addr;
    logic                  w_push;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;
    logic [COUNT_BITS-1:0] w_newc;
    logic                  w_clr_last;

    pgbh_pkg::t_bin_res    w_bin;
    logic [CW-1:0]         w_bcol;
    logic [RW-1:0]         w_brow;
    logic                  w_gstart;
    logic                  w_gdone;
    logic [7:0]            w_gpix;

    pgbh_bin #(
        .MAX_COLS (MAX_COLS), .MAX_ROWS (MAX_ROWS),
        .CW (CW), .RW (RW), .LCW (LCW), .LRW (LRW)
    ) u_bin (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && (i_in.cmd == pgbh_pkg::CMD_ADD)),
        .i_point_x  (i_in.point_x),
        .i_point_y  (i_in.point_y),
        .i_origin_x (r_origin_x),
        .i_origin_y (r_origin_y),
        .i_inv_x    (r_inv_x),
        .i_inv_y    (r_inv_y),
        .i_cols     (w_cols),
        .i_rows     (w_rows),
        .o_res      (w_bin),
        .o_col      (w_bcol),
        .o_row      (w_brow)
    );

    pgbh_gray #(.COUNT_BITS(COUNT_BITS), .RATIO_BITS(RATIO_BITS)) u_gray (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gstart),
        .i_count (r_rdata),
        .i_peak  (r_peak),
        .o_done  (w_gdone),
        .o_pixel (w_gpix)
    );

    // Clamp grid extents and form addresses
    always_comb begin
        if (r_gcols == '0) begin
            w_cols = LCW'(1);
        end else if (32'(r_gcols) > 32'(MAX_COLS)) begin
            w_cols = LCW'(MAX_COLS);
        end else begin
            w_cols = LCW'(r_gcols);
        end
        if (r_grows == '0) begin
            w_rows = LRW'(1);
        end else if (32'(r_grows) > 32'(MAX_ROWS)) begin
            w_rows = LRW'(MAX_ROWS);
        end else begin
            w_rows = LRW'(r_grows);
        end
        w_accept   = i_in.valid && (r_state == S_IDLE);
        w_rd_ok    = (32'(i_in.read_col) < 32'(w_cols)) && (32'(i_in.read_row) < 32'(w_rows));
        w_rd_addr  = AW'(AW'(i_in.read_row) * AW'(MAX_COLS) + AW'(i_in.read_col));
        w_bin_addr = AW'(AW'(w_brow) * AW'(MAX_COLS) + AW'(w_bcol));
        w_newc     = (r_rdata == SAT) ? r_rdata : r_rdata + 1'b1;
        w_clr_last = (32'(r_clr_idx) == 32'(DEPTH - 1));
        w_push     = (r_state == S_DONE) && (!r_ovalid || o_out.ready);
        w_gstart   = (r_state == S_MOD) && !r_is_add && !r_binary;
        // Write zeros while clearing, the new count after an add
        w_we       = (r_state == S_CLR) || ((r_state == S_MOD) && r_is_add);
        w_waddr    = (r_state == S_CLR) ? r_clr_idx : r_addr;
        w_wdata    = (r_state == S_CLR) ? '0 : w_newc;
    end

    // Memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_inv_x    <= 32'd65536;
            r_inv_y    <= 32'd65536;
            r_gcols    <= pgbh_pkg::GRID_W'(1);
            r_grows    <= pgbh_pkg::GRID_W'(1);
            r_binary   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pgbh_pkg::CFG_ORIGIN_X:   r_origin_x <= i_cfg_data;
                pgbh_pkg::CFG_ORIGIN_Y:   r_origin_y <= i_cfg_data;
                pgbh_pkg::CFG_INV_CELL_X: r_inv_x    <= i_cfg_data;
                pgbh_pkg::CFG_INV_CELL_Y: r_inv_y    <= i_cfg_data;
                pgbh_pkg::CFG_GRID_COLS:  r_gcols    <= i_cfg_data[pgbh_pkg::GRID_W-1:0];
                pgbh_pkg::CFG_GRID_ROWS:  r_grows    <= i_cfg_data[pgbh_pkg::GRID_W-1:0];
                pgbh_pkg::CFG_BINARY:     r_binary   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Command sequencer, totals and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
            r_clr_res <= 1'b0;
            r_is_add  <= 1'b0;
            r_addr    <= '0;
            r_peak    <= '0;
            r_occ     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (w_push) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (w_clr_last) begin
                        r_clr_idx <= '0;
                        r_state   <= r_clr_res ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in.cmd)
                            pgbh_pkg::CMD_CLEAR: begin
                                r_peak    <= '0;
                                r_occ     <= '0;
                                r_clr_res <= 1'b1;
                                r_state   <= S_CLR;
                            end
                            pgbh_pkg::CMD_ADD: begin
                                r_state <= S_BIN;
                            end
                            pgbh_pkg::CMD_READ: begin
                                r_is_add <= 1'b0;
                                r_addr   <= w_rd_addr;
                                r_state  <= w_rd_ok ? S_RD : S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_BIN: begin
                    if (w_bin.done) begin
                        r_is_add <= 1'b1;
                        r_addr   <= w_bin_addr;
                        r_state  <= w_bin.ok ? S_RD : S_DONE;
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_is_add) begin
                        if (r_rdata == '0) begin
                            r_occ <= r_occ + 1'b1;
                        end
                        if (w_newc > r_peak) begin
                            r_peak <= w_newc;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_state <= r_binary ? S_DONE : S_GRAY;
                    end
                end
                S_GRAY: begin
                    if (w_gdone) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_push) begin
                        r_clr_res <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Build the pending result
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_res_col <= '0;
                r_res_row <= '0;
                r_res_ok  <= 1'b0;
                r_res_cnt <= '0;
                r_res_pix <= '0;
                if (w_accept && (i_in.cmd == pgbh_pkg::CMD_READ)) begin
                    r_res_col <= i_in.read_col;
                    r_res_row <= i_in.read_row;
                    r_res_ok  <= w_rd_ok;
                end
            end
            S_BIN: begin
                if (w_bin.done && w_bin.ok) begin
                    r_res_col <= 8'(w_bcol);
                    r_res_row <= 8'(w_brow);
                    r_res_ok  <= 1'b1;
                end
            end
            S_MOD: begin
                if (r_is_add) begin
                    r_res_cnt <= w_newc;
                end else begin
                    r_res_cnt <= r_rdata;
                    r_res_pix <= (r_binary && (r_rdata != '0)) ? pgbh_pkg::PIX_FULL : '0;
                end
            end
            S_GRAY: begin
                if (w_gdone) begin
                    r_res_pix <= w_gpix;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register, loaded when free or being taken
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_o_col <= r_res_col;
            r_o_row <= r_res_row;
            r_o_ok  <= r_res_ok;
            r_o_cnt <= 16'(r_res_cnt);
            r_o_pix <= r_res_pix;
            r_o_occ <= 17'(r_occ);
            r_o_max <= 16'(r_peak);
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_ovalid;
    assign o_out.cell_col       = r_o_col;
    assign o_out.cell_row       = r_o_row;
    assign o_out.in_range       = r_o_ok;
    assign o_out.cell_count     = r_o_cnt;
    assign o_out.pixel          = r_o_pix;
    assign o_out.occupied_total = r_o_occ;
    assign o_out.max_count      = r_o_max;
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for point_grid_binning_histogram: directed table, a
// saturation run, random phases, checked against a model. Uses pgbh_pkg, pgbh_if.
`timescale 1ns / 1ps
module tb_top;
    import pgbh_pkg::*;

    typedef struct packed {
        logic [7:0]  col;
        logic [7:0]  row;
        logic        ok;
        logic [15:0] cnt;
        logic [7:0]  pix;
        logic [16:0] occ;
        logic [15:0] peak;
    } cell_res_t;

    typedef struct {
        bit              is_cfg;
        logic [2:0]      cfg_idx;
        logic [31:0]     cfg_val;
        logic [1:0]      cmd;
        logic [31:0]     px;
        logic [31:0]     py;
        logic [7:0]      rc;
        logic [7:0]      rr;
        bit              typed;
        cell_res_t       res;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pgbh_in_if  in_ch ();
    pgbh_out_if out_ch ();

    point_grid_binning_histogram i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.source),
        .o_out      (out_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    // Model state: cell store, totals and register copies
    logic [15:0] grid_cnt [0:65535];
    logic [15:0] m_peak;
    logic [16:0] m_occ;
    logic [31:0] m_ox, m_oy, m_invx, m_invy;
    logic [8:0]  m_cols, m_rows;
    logic        m_bin;

    cell_res_t expected_cells [$];
    int  err_cnt = 0;
    int  burst_left = 0;
    bit  fast_mode = 0;
    dir_row_t dir_tab [0:19];

    function automatic int grid_extent(logic [8:0] v);
        if (v == 0) return 1;
        return (v > 256) ? 256 : int'(v);
    endfunction

    // Floor of d * inv / 2^32; 0 when negative or at or past the limit
    function automatic bit bin_axis(logic signed [32:0] d, logic [31:0] inv, int lim,
                                    output int idx);
        logic [63:0] prod;
        idx = 0;
        if (d < 0) begin
            prod = 64'(-d) * 64'(inv);
            return (prod == 0);
        end
        prod = 64'(d) * 64'(inv);
        if ((prod >> 32) >= 64'(lim)) return 0;
        idx = int'(prod >> 32);
        return 1;
    endfunction

    // tanh shade from the count/peak ratio via a Taylor series of exp
    function automatic logic [7:0] tanh_shade(logic [15:0] c);
        logic [63:0] r, y, t, e;
        if (m_peak == 0 || c == 0) return 8'd0;
        r = (64'(c) << 10) / 64'(m_peak);
        y = r << 19;
        t = 64'(Q28_ONE);
        e = t;
        for (int k = 1; k <= int'(TAYLOR_TERMS); k++) begin
            t = (t * y) / (64'(k) << 28);
            e = e + t;
        end
        return 8'((64'd255 * (e - 64'(Q28_ONE))) / (e + 64'(Q28_ONE)));
    endfunction

    // Apply one command to the model and return its result item
    function automatic cell_res_t bin_and_count(logic [1:0] cmd, logic [31:0] px,
                                                logic [31:0] py, logic [7:0] rc,
                                                logic [7:0] rr);
        cell_res_t o;
        int cols, rows, cx, cy, a;
        bit okx, oky;
        logic [15:0] c;
        o = '0;
        cols = grid_extent(m_cols);
        rows = grid_extent(m_rows);
        if (cmd == CMD_CLEAR) begin
            for (int i = 0; i < 65536; i++) grid_cnt[i] = '0;
            m_peak = '0;
            m_occ = '0;
        end else if (cmd == CMD_ADD) begin
            okx = bin_axis(33'(signed'(px)) - 33'(signed'(m_ox)), m_invx, cols, cx);
            oky = bin_axis(33'(signed'(py)) - 33'(signed'(m_oy)), m_invy, rows, cy);
            if (okx && oky) begin
                a = cy * 256 + cx;
                c = grid_cnt[a];
                if (c == 0) m_occ = m_occ + 1;
                if (c != 16'hFFFF) c = c + 1;
                grid_cnt[a] = c;
                if (c > m_peak) m_peak = c;
                o.col = 8'(cx);
                o.row = 8'(cy);
                o.ok = 1'b1;
                o.cnt = c;
            end
        end else if (cmd == CMD_READ) begin
            o.col = rc;
            o.row = rr;
            if (int'(rc) < cols && int'(rr) < rows) begin
                o.ok = 1'b1;
                o.cnt = grid_cnt[int'(rr) * 256 + int'(rc)];
                if (m_bin) o.pix = (o.cnt != 0) ? PIX_FULL : 8'd0;
                else o.pix = tanh_shade(o.cnt);
            end
        end
        o.occ = m_occ;
        o.peak = m_peak;
        return o;
    endfunction

    // Write one register; called at a falling edge, returns at one
    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        case (idx)
            CFG_ORIGIN_X:   m_ox = val;
            CFG_ORIGIN_Y:   m_oy = val;
            CFG_INV_CELL_X: m_invx = val;
            CFG_INV_CELL_Y: m_invy = val;
            CFG_GRID_COLS:  m_cols = val[8:0];
            CFG_GRID_ROWS:  m_rows = val[8:0];
            CFG_BINARY:     m_bin = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Hold off until every expected result has arrived
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (expected_cells.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Offer one command item in bursts; queue its expected result on accept
    task automatic send_cmd(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
                            logic [7:0] rc, logic [7:0] rr, bit typed, cell_res_t tv);
        cell_res_t pv;
        if (!fast_mode && burst_left == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        in_ch.cmd = cmd;
        in_ch.point_x = px;
        in_ch.point_y = py;
        in_ch.read_col = rc;
        in_ch.read_row = rr;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        pv = bin_and_count(cmd, px, py, rc, rr);
        expected_cells.push_back(typed ? tv : pv);
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
    endtask

    // Receiver stall pattern: a random mode for each run of random length
    int rx_mode = 0;
    int rx_left = 0;
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(8, 60);
        end
        rx_left--;
        if (fast_mode || rx_mode == 0) out_ch.ready <= 1'b1;
        else if (rx_mode == 1) out_ch.ready <= ($urandom_range(0, 1) == 1);
        else if (rx_mode == 2) out_ch.ready <= (rx_left % 4 != 0);
        else out_ch.ready <= ($urandom_range(0, 7) == 0);
    end

    task automatic check_field(string name, longint e, longint a);
        if (e != a) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
            err_cnt++;
        end
    endtask

    // Compare each accepted result item with the oldest expectation
    always @(posedge i_clk) begin
        cell_res_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_cells.size() == 0) begin
                $display("%0t unexpected result item col %0d row %0d", $time,
                         out_ch.cell_col, out_ch.cell_row);
                err_cnt++;
            end else begin
                e = expected_cells.pop_front();
                check_field("cell_col", e.col, out_ch.cell_col);
                check_field("cell_row", e.row, out_ch.cell_row);
                check_field("in_range", e.ok, out_ch.in_range);
                check_field("cell_count", e.cnt, out_ch.cell_count);
                check_field("pixel", e.pix, out_ch.pixel);
                check_field("occupied_total", e.occ, out_ch.occupied_total);
                check_field("max_count", e.peak, out_ch.max_count);
            end
        end
    end

    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [31:0] ox, oy, invx, invy, px, py;
        logic [63:0] cwx, cwy;
        int cols, rows, cx, cy, rsel, read_pct;
        cell_res_t z;
        z = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_CLEAR;
        in_ch.point_x = '0;
        in_ch.point_y = '0;
        in_ch.read_col = '0;
        in_ch.read_row = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < 65536; i++) grid_cnt[i] = '0;
        m_peak = '0; m_occ = '0; m_ox = '0; m_oy = '0;
        m_invx = 32'd65536; m_invy = 32'd65536;
        m_cols = 9'd1; m_rows = 9'd1; m_bin = 1'b0;

        // Directed rows: 1x1 grid of unit cells after reset, then 1x256 binary
        dir_tab[0]  = '{0, 0, 0, CMD_READ, 0, 0, 0, 0, 1, '{0, 0, 1, 0, 0, 0, 0}};
        dir_tab[1]  = '{0, 0, 0, CMD_ADD, 0, 0, 0, 0, 1, '{0, 0, 1, 1, 0, 1, 1}};
        dir_tab[2]  = '{0, 0, 0, CMD_ADD, 32'h0000FFFF, 32'h0000FFFF, 0, 0, 1,
                        '{0, 0, 1, 2, 0, 1, 2}};
        dir_tab[3]  = '{0, 0, 0, CMD_READ, 0, 0, 0, 0, 0, z};
        dir_tab[4]  = '{0, 0, 0, CMD_ADD, 32'hFFFFFFFF, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1, 2}};
        dir_tab[5]  = '{0, 0, 0, CMD_ADD, 32'h7FFFFFFF, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1, 2}};
        dir_tab[6]  = '{0, 0, 0, CMD_ADD, 32'h80000000, 32'h80000000, 0, 0, 1,
                        '{0, 0, 0, 0, 0, 1, 2}};
        dir_tab[7]  = '{0, 0, 0, CMD_ADD, 0, 32'h00010000, 0, 0, 1, '{0, 0, 0, 0, 0, 1, 2}};
        dir_tab[8]  = '{0, 0, 0, 2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF, 1,
                        '{0, 0, 0, 0, 0, 1, 2}};
        dir_tab[9]  = '{0, 0, 0, CMD_READ, 0, 0, 8'hFF, 8'hFF, 1, '{255, 255, 0, 0, 0, 1, 2}};
        dir_tab[10] = '{0, 0, 0, CMD_READ, 0, 0, 1, 0, 1, '{1, 0, 0, 0, 0, 1, 2}};
        dir_tab[11] = '{0, 0, 0, CMD_CLEAR, 0, 0, 0, 0, 1, z};
        dir_tab[12] = '{0, 0, 0, CMD_READ, 0, 0, 0, 0, 1, '{0, 0, 1, 0, 0, 0, 0}};
        dir_tab[13] = '{1, CFG_GRID_COLS, 32'd0, 0, 0, 0, 0, 0, 0, z};
        dir_tab[14] = '{1, CFG_GRID_ROWS, 32'd300, 0, 0, 0, 0, 0, 0, z};
        dir_tab[15] = '{1, CFG_BINARY, 32'd1, 0, 0, 0, 0, 0, 0, z};
        dir_tab[16] = '{0, 0, 0, CMD_ADD, 0, 32'h00FF0000, 0, 0, 1, '{0, 255, 1, 1, 0, 1, 1}};
        dir_tab[17] = '{0, 0, 0, CMD_READ, 0, 0, 0, 8'hFF, 1, '{0, 255, 1, 1, 255, 1, 1}};
        dir_tab[18] = '{0, 0, 0, CMD_READ, 0, 0, 0, 1, 1, '{0, 1, 1, 0, 0, 1, 1}};
        dir_tab[19] = '{0, 0, 0, CMD_ADD, 0, 32'h01000000, 0, 0, 1, '{0, 0, 0, 0, 0, 1, 1}};

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                wait_drained();
                cfg_write(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
            end else begin
                send_cmd(dir_tab[i].cmd, dir_tab[i].px, dir_tab[i].py, dir_tab[i].rc,
                         dir_tab[i].rr, dir_tab[i].typed, dir_tab[i].res);
            end
        end

        // Drive one cell to saturation at full rate, then read it and another cell in gray mode
        wait_drained();
        cfg_write(CFG_BINARY, 32'd0);
        fast_mode = 1;
        for (int i = 0; i < 65540; i++) send_cmd(CMD_ADD, 0, 0, 0, 0, 0, z);
        send_cmd(CMD_READ, 0, 0, 0, 0, 0, z);
        send_cmd(CMD_READ, 0, 0, 0, 8'hFF, 0, z);
        fast_mode = 0;

        // Random phases with fresh settings, extremes among them
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            ox = (p == 1) ? 32'h80000000 : (p == 2) ? 32'h7FFFFFFF : $urandom;
            oy = (p == 1) ? 32'h7FFFFFFF : (p == 2) ? 32'h80000000 : $urandom;
            invx = (p == 3) ? 32'hFFFFFFFF : (p == 4) ? 32'd1
                 : (32'd1 << $urandom_range(12, 22)) | ((p > 5) ? $urandom_range(0, 4095) : 0);
            invy = (p == 3) ? 32'd1 : (p == 4) ? 32'hFFFFFFFF
                 : (32'd1 << $urandom_range(12, 22)) | ((p > 5) ? $urandom_range(0, 4095) : 0);
            cfg_write(CFG_ORIGIN_X, ox);
            cfg_write(CFG_ORIGIN_Y, oy);
            cfg_write(CFG_INV_CELL_X, invx);
            cfg_write(CFG_INV_CELL_Y, invy);
            cfg_write(CFG_GRID_COLS, (p == 0) ? 32'd256 : (p == 5) ? 32'd0
                                     : 32'($urandom_range(1, 300)));
            cfg_write(CFG_GRID_ROWS, (p == 0) ? 32'd256 : (p == 5) ? 32'd511
                                     : 32'($urandom_range(1, 300)));
            cfg_write(CFG_BINARY, (p % 2 == 0) ? 32'd1 : 32'd0);
            cols = grid_extent(m_cols);
            rows = grid_extent(m_rows);
            cwx = 64'h1_0000_0000 / 64'(invx);
            cwy = 64'h1_0000_0000 / 64'(invy);
            read_pct = m_bin ? 25 : 8;
            if (p == 2 || p == 6) send_cmd(CMD_CLEAR, $urandom, $urandom, 0, 0, 0, z);
            for (int n = 0; n < 200; n++) begin
                rsel = $urandom_range(0, 99);
                if (rsel < 3) begin
                    // Noise: unused command code with random fields
                    send_cmd(2'd3, $urandom, $urandom, 8'($urandom), 8'($urandom), 0, z);
                end else if (rsel < 3 + read_pct) begin
                    if ($urandom_range(0, 3) == 0) begin
                        cx = $urandom_range(0, 255);
                        cy = $urandom_range(0, 255);
                    end else begin
                        cx = $urandom_range(0, cols - 1);
                        cy = $urandom_range(0, rows - 1);
                    end
                    send_cmd(CMD_READ, $urandom, $urandom, 8'(cx), 8'(cy), 0, z);
                end else if ($urandom_range(0, 3) == 0) begin
                    send_cmd(CMD_ADD, $urandom, $urandom, 8'($urandom), 8'($urandom), 0, z);
                end else begin
                    // Aim inside the grid, half the time within the first four columns and rows
                    if ($urandom_range(0, 1) == 0) begin
                        cx = $urandom_range(0, (cols < 4 ? cols : 4) - 1);
                        cy = $urandom_range(0, (rows < 4 ? rows : 4) - 1);
                    end else begin
                        cx = $urandom_range(0, cols - 1);
                        cy = $urandom_range(0, rows - 1);
                    end
                    px = 32'(64'(ox) + 64'(cx) * cwx + ({$urandom, $urandom} % cwx));
                    py = 32'(64'(oy) + 64'(cy) * cwy + ({$urandom, $urandom} % cwy));
                    send_cmd(CMD_ADD, px, py, 8'($urandom), 8'($urandom), 0, z);
                end
            end
        end

        // Drain and settle
        in_ch.valid = 1'b0;
        while (expected_cells.size() != 0) @(negedge i_clk);
        repeat (1200) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
